// ===== hw/rtl/wpam_pkg.sv =====
// shared widths, action codes, register indexes and reset values for the weld monitor
package wpam_pkg;

  localparam int SAMPLE_BITS   = 10;
  localparam int FRACTION_BITS = 6;
  localparam int AVG_BITS      = SAMPLE_BITS + FRACTION_BITS;
  localparam int CNT_BITS      = 17;
  localparam int WAIT_BITS     = 16;
  localparam int PULSE_BITS    = 16;
  localparam int SKIP_BITS     = 8;
  localparam int COUNT_BITS    = 8;
  localparam int DIVISOR_BITS  = COUNT_BITS + 1;
  localparam int SUM_BITS      = AVG_BITS + COUNT_BITS + 1;
  localparam int STEP_BITS     = $clog2(SUM_BITS);
  localparam int ACTION_BITS   = 2;
  localparam int REG_BITS      = 3;
  localparam int ADDR_BITS     = REG_BITS + 2;
  localparam int DATA_BITS     = 32;

  localparam logic [ACTION_BITS-1:0] ACT_TICK   = 2'd0;
  localparam logic [ACTION_BITS-1:0] ACT_START  = 2'd1;
  localparam logic [ACTION_BITS-1:0] ACT_FINISH = 2'd2;

  localparam logic [REG_BITS-1:0] REG_CURRENT_HIGH    = 3'd0;
  localparam logic [REG_BITS-1:0] REG_CURRENT_LOW     = 3'd1;
  localparam logic [REG_BITS-1:0] REG_VOLT_LOW        = 3'd2;
  localparam logic [REG_BITS-1:0] REG_VOLT_HIGH       = 3'd3;
  localparam logic [REG_BITS-1:0] REG_SHORT_THRESHOLD = 3'd4;
  localparam logic [REG_BITS-1:0] REG_SKIP_SAMPLES    = 3'd5;
  localparam logic [REG_BITS-1:0] REG_AVERAGE_SAMPLES = 3'd6;
  localparam logic [REG_BITS-1:0] REG_WAIT_TICKS      = 3'd7;

  localparam logic [SAMPLE_BITS-1:0] RST_CURRENT_HIGH    = 10'd200;
  localparam logic [SAMPLE_BITS-1:0] RST_CURRENT_LOW     = 10'd100;
  localparam logic [SAMPLE_BITS-1:0] RST_VOLT_LOW        = 10'd100;
  localparam logic [SAMPLE_BITS-1:0] RST_VOLT_HIGH       = 10'd900;
  localparam logic [SAMPLE_BITS-1:0] RST_SHORT_THRESHOLD = 10'd20;
  localparam logic [SKIP_BITS-1:0]   RST_SKIP_SAMPLES    = 8'd4;
  localparam logic [COUNT_BITS-1:0]  RST_AVERAGE_SAMPLES = 8'd16;
  localparam logic [WAIT_BITS-1:0]   RST_WAIT_TICKS      = 16'd50;

endpackage

// ===== hw/rtl/weld_pulse_and_arc_monitor.sv =====
// weld pulse and arc monitor: pulse timer, short and arc detection, voltage averager
//
// one input item per sampling tick on in_valid/in_stall: an action (tick, start
// pulse, finish pulse), a pulse length and raw voltage and current samples
// one result item per input item on out_valid/out_stall: switch and arc levels,
// spark-fail, short circuit and averaged voltage report
// the result is registered and shows in the cycle after the input item is taken
// an item that adds a sample to the running average then keeps the block busy
// through a multiply state and a radix-2 restoring divider state, one quotient
// bit per cycle; every other item leaves the block idle, so the block sustains
// 1 item per cycle without averaging while the output is not stalled
// a stalled result holds in the output register; a new item is taken only once
// the divider is free and the output register is empty or being drained
// thresholds sit in an apb register file, one register per 4-byte word; the user
// must write them only while the block is idle, as the block does not enforce it
// reads return the register value; synchronous reset stops the pulse, clears arc
// and averager state, loads the register defaults and the skip count, and empties
// the output register; the input is stalled while reset is held
module weld_pulse_and_arc_monitor (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [wpam_pkg::ADDR_BITS-1:0]        paddr,
  input  logic [wpam_pkg::DATA_BITS-1:0]        pwdata,
  output logic [wpam_pkg::DATA_BITS-1:0]        prdata,
  output logic                                  pready,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [wpam_pkg::ACTION_BITS-1:0]      action,
  input  logic [wpam_pkg::PULSE_BITS-1:0]       pulse_ticks,
  input  logic [wpam_pkg::SAMPLE_BITS-1:0]      voltage_sample,
  input  logic [wpam_pkg::SAMPLE_BITS-1:0]      current_sample,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  switch_on,
  output logic                                  arc_present,
  output logic                                  spark_fail,
  output logic                                  short_seen,
  output logic [wpam_pkg::SAMPLE_BITS-1:0]      short_voltage,
  output logic                                  report_valid,
  output logic [wpam_pkg::AVG_BITS-1:0]         report_voltage
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  // configuration
  logic [wpam_pkg::SAMPLE_BITS-1:0] current_high;
  logic [wpam_pkg::SAMPLE_BITS-1:0] current_low;
  logic [wpam_pkg::SAMPLE_BITS-1:0] volt_low;
  logic [wpam_pkg::SAMPLE_BITS-1:0] volt_high;
  logic [wpam_pkg::SAMPLE_BITS-1:0] short_threshold;
  logic [wpam_pkg::SKIP_BITS-1:0]   skip_samples;
  logic [wpam_pkg::COUNT_BITS-1:0]  average_samples;
  logic [wpam_pkg::WAIT_BITS-1:0]   wait_ticks;

  // block state
  logic                             pulse_running;
  logic [wpam_pkg::CNT_BITS-1:0]    tick_counter;
  logic [wpam_pkg::CNT_BITS-1:0]    pulse_end;
  logic                             arc_flag;
  logic                             switch_level;
  logic [wpam_pkg::AVG_BITS-1:0]    voltage_average;
  logic [wpam_pkg::COUNT_BITS-1:0]  averaged_count;
  logic [wpam_pkg::SKIP_BITS-1:0]   skips_left;

  // sequencer and divider
  logic [1:0]                         state;
  logic [wpam_pkg::SAMPLE_BITS-1:0]   div_sample;
  logic [wpam_pkg::SUM_BITS-1:0]      div_quot;
  logic [wpam_pkg::COUNT_BITS-1:0]    div_rem;
  logic [wpam_pkg::STEP_BITS-1:0]     div_step;
  logic [wpam_pkg::DIVISOR_BITS-1:0]  divisor;
  logic [wpam_pkg::DIVISOR_BITS-1:0]  div_trial;
  logic                               div_bit;
  logic [wpam_pkg::SUM_BITS-1:0]      div_quot_next;

  // per-item next values
  logic                             in_accept;
  logic                             cfg_write;
  logic [wpam_pkg::REG_BITS-1:0]    reg_index;
  logic [wpam_pkg::CNT_BITS-1:0]    wait_ext;
  logic                             running_next;
  logic [wpam_pkg::CNT_BITS-1:0]    counter_next;
  logic [wpam_pkg::CNT_BITS-1:0]    pulse_end_next;
  logic                             switch_next;
  logic                             arc_next;
  logic [wpam_pkg::SKIP_BITS-1:0]   skips_next;
  logic [wpam_pkg::COUNT_BITS-1:0]  count_next;
  logic [wpam_pkg::AVG_BITS-1:0]    average_next;
  logic                             fail_next;
  logic                             short_next;
  logic                             report_next;
  logic                             start_div;
  logic                             in_window;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = rst || (state != ST_IDLE) || (out_valid && out_stall);
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_index = paddr[wpam_pkg::ADDR_BITS-1:2];
  assign pready    = 1'b1;
  assign wait_ext  = {1'b0, wait_ticks};
  assign in_window = (voltage_sample > volt_low) && (voltage_sample < volt_high);

  always_comb begin
    case (reg_index)
      wpam_pkg::REG_CURRENT_HIGH:    prdata = wpam_pkg::DATA_BITS'(current_high);
      wpam_pkg::REG_CURRENT_LOW:     prdata = wpam_pkg::DATA_BITS'(current_low);
      wpam_pkg::REG_VOLT_LOW:        prdata = wpam_pkg::DATA_BITS'(volt_low);
      wpam_pkg::REG_VOLT_HIGH:       prdata = wpam_pkg::DATA_BITS'(volt_high);
      wpam_pkg::REG_SHORT_THRESHOLD: prdata = wpam_pkg::DATA_BITS'(short_threshold);
      wpam_pkg::REG_SKIP_SAMPLES:    prdata = wpam_pkg::DATA_BITS'(skip_samples);
      wpam_pkg::REG_AVERAGE_SAMPLES: prdata = wpam_pkg::DATA_BITS'(average_samples);
      wpam_pkg::REG_WAIT_TICKS:      prdata = wpam_pkg::DATA_BITS'(wait_ticks);
      default:                       prdata = '0;
    endcase
  end

  always_comb begin
    running_next   = pulse_running;
    counter_next   = tick_counter;
    pulse_end_next = pulse_end;
    switch_next    = switch_level;
    arc_next       = arc_flag;
    skips_next     = skips_left;
    count_next     = averaged_count;
    average_next   = voltage_average;
    fail_next      = 1'b0;
    short_next     = 1'b0;
    report_next    = 1'b0;
    start_div      = 1'b0;
    case (action)
      wpam_pkg::ACT_START: begin
        counter_next   = '0;
        pulse_end_next = wait_ext + wpam_pkg::CNT_BITS'(pulse_ticks);
        running_next   = 1'b1;
      end
      wpam_pkg::ACT_FINISH: begin
        running_next = 1'b0;
        switch_next  = 1'b0;
        counter_next = '0;
      end
      wpam_pkg::ACT_TICK: begin
        // pulse timer
        if (pulse_running) begin
          if (tick_counter == '0) begin
            switch_next = 1'b1;
          end
          if (tick_counter == pulse_end) begin
            switch_next  = 1'b0;
            running_next = 1'b0;
            counter_next = '0;
          end else begin
            counter_next = tick_counter + 1'b1;
          end
          if (arc_flag && (counter_next < wait_ext)) begin
            counter_next = wait_ext;
          end
          if (!arc_flag && (counter_next >= wait_ext)) begin
            counter_next = pulse_end;
            fail_next    = 1'b1;
          end
        end
        // short circuit
        if (voltage_sample < short_threshold) begin
          running_next = 1'b0;
          switch_next  = 1'b0;
          counter_next = '0;
          short_next   = 1'b1;
        end
        // arc hysteresis and averager
        if (current_sample > current_high) begin
          arc_next = 1'b1;
          if (in_window) begin
            if ((skips_left == '0) && (averaged_count < average_samples)) begin
              start_div = 1'b1;
            end else if (skips_left != '0) begin
              skips_next = skips_left - 1'b1;
            end
          end
        end else if (arc_flag && (current_sample < current_low)) begin
          arc_next    = 1'b0;
          report_next = (averaged_count == average_samples)
                     && (voltage_average > {volt_low, wpam_pkg::FRACTION_BITS'(0)})
                     && (voltage_average < {volt_high, wpam_pkg::FRACTION_BITS'(0)});
          average_next = '0;
          skips_next   = skip_samples;
          count_next   = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // restoring divider step
  assign divisor       = {1'b0, averaged_count} + 1'b1;
  assign div_trial     = {div_rem, div_quot[wpam_pkg::SUM_BITS-1]};
  assign div_bit       = div_trial >= divisor;
  assign div_quot_next = {div_quot[wpam_pkg::SUM_BITS-2:0], div_bit};

  always_ff @(posedge clk) begin
    if (rst) begin
      current_high    <= wpam_pkg::RST_CURRENT_HIGH;
      current_low     <= wpam_pkg::RST_CURRENT_LOW;
      volt_low        <= wpam_pkg::RST_VOLT_LOW;
      volt_high       <= wpam_pkg::RST_VOLT_HIGH;
      short_threshold <= wpam_pkg::RST_SHORT_THRESHOLD;
      skip_samples    <= wpam_pkg::RST_SKIP_SAMPLES;
      average_samples <= wpam_pkg::RST_AVERAGE_SAMPLES;
      wait_ticks      <= wpam_pkg::RST_WAIT_TICKS;
    end else if (cfg_write) begin
      case (reg_index)
        wpam_pkg::REG_CURRENT_HIGH:    current_high    <= pwdata[wpam_pkg::SAMPLE_BITS-1:0];
        wpam_pkg::REG_CURRENT_LOW:     current_low     <= pwdata[wpam_pkg::SAMPLE_BITS-1:0];
        wpam_pkg::REG_VOLT_LOW:        volt_low        <= pwdata[wpam_pkg::SAMPLE_BITS-1:0];
        wpam_pkg::REG_VOLT_HIGH:       volt_high       <= pwdata[wpam_pkg::SAMPLE_BITS-1:0];
        wpam_pkg::REG_SHORT_THRESHOLD: short_threshold <= pwdata[wpam_pkg::SAMPLE_BITS-1:0];
        wpam_pkg::REG_SKIP_SAMPLES:    skip_samples    <= pwdata[wpam_pkg::SKIP_BITS-1:0];
        wpam_pkg::REG_AVERAGE_SAMPLES: average_samples <= pwdata[wpam_pkg::COUNT_BITS-1:0];
        wpam_pkg::REG_WAIT_TICKS:      wait_ticks      <= pwdata[wpam_pkg::WAIT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_running   <= 1'b0;
      tick_counter    <= '0;
      pulse_end       <= '0;
      arc_flag        <= 1'b0;
      switch_level    <= 1'b0;
      voltage_average <= '0;
      averaged_count  <= '0;
      skips_left      <= wpam_pkg::RST_SKIP_SAMPLES;
      state           <= ST_IDLE;
      out_valid       <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            pulse_running   <= running_next;
            tick_counter    <= counter_next;
            pulse_end       <= pulse_end_next;
            arc_flag        <= arc_next;
            switch_level    <= switch_next;
            voltage_average <= average_next;
            averaged_count  <= count_next;
            skips_left      <= skips_next;
            out_valid       <= 1'b1;
            if (start_div) begin
              state <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_step == wpam_pkg::STEP_BITS'(wpam_pkg::SUM_BITS - 1)) begin
            voltage_average <= div_quot_next[wpam_pkg::AVG_BITS-1:0];
            averaged_count  <= averaged_count + 1'b1;
            state           <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // averaging datapath
  always_ff @(posedge clk) begin
    if (in_accept) begin
      div_sample <= voltage_sample;
    end
    case (state)
      ST_MUL: begin
        div_quot <= wpam_pkg::SUM_BITS'(voltage_average)
                    * wpam_pkg::SUM_BITS'(averaged_count)
                  + (wpam_pkg::SUM_BITS'(div_sample) << wpam_pkg::FRACTION_BITS)
                  + wpam_pkg::SUM_BITS'(divisor >> 1);
        div_rem  <= '0;
        div_step <= '0;
      end
      ST_DIV: begin
        div_quot <= div_quot_next;
        div_rem  <= div_bit ? wpam_pkg::COUNT_BITS'(div_trial - divisor)
                            : div_trial[wpam_pkg::COUNT_BITS-1:0];
        div_step <= div_step + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (in_accept) begin
      switch_on      <= switch_next;
      arc_present    <= arc_next;
      spark_fail     <= fail_next;
      short_seen     <= short_next;
      short_voltage  <= short_next ? voltage_sample : '0;
      report_valid   <= report_next;
      report_voltage <= report_next ? voltage_average : '0;
    end
  end

endmodule

// ===== tb/weld_pulse_and_arc_monitor_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the weld pulse and arc monitor with a scoreboard and predictor
module weld_pulse_and_arc_monitor_tb;

  localparam logic [wpam_pkg::ACTION_BITS-1:0] ACT_NONE = 2'd3;
  localparam int SAMPLE_MAX = (1 << wpam_pkg::SAMPLE_BITS) - 1;
  localparam int DIVIDE_GAP = 32;

  typedef struct packed {
    logic                             sw;
    logic                             arc;
    logic                             fail;
    logic                             shrt;
    logic [wpam_pkg::SAMPLE_BITS-1:0] short_v;
    logic                             rep;
    logic [wpam_pkg::AVG_BITS-1:0]    rep_v;
  } weld_result_t;

  class weld_scoreboard_t;
    logic [wpam_pkg::SAMPLE_BITS-1:0] cur_hi, cur_lo, v_lo, v_hi, short_th;
    logic [wpam_pkg::SKIP_BITS-1:0]   skip_n;
    logic [wpam_pkg::COUNT_BITS-1:0]  avg_n;
    logic [wpam_pkg::WAIT_BITS-1:0]   wait_n;
    logic                             running, arc, sw;
    logic [wpam_pkg::CNT_BITS-1:0]    tick, pend;
    logic [wpam_pkg::AVG_BITS-1:0]    avg;
    logic [wpam_pkg::COUNT_BITS-1:0]  cnt;
    logic [wpam_pkg::SKIP_BITS-1:0]   skips;
    weld_result_t                     expected_q[$];
    int                               errors;

    function new();
      cur_hi = wpam_pkg::RST_CURRENT_HIGH;
      cur_lo = wpam_pkg::RST_CURRENT_LOW;
      v_lo = wpam_pkg::RST_VOLT_LOW;
      v_hi = wpam_pkg::RST_VOLT_HIGH;
      short_th = wpam_pkg::RST_SHORT_THRESHOLD;
      skip_n = wpam_pkg::RST_SKIP_SAMPLES;
      avg_n = wpam_pkg::RST_AVERAGE_SAMPLES;
      wait_n = wpam_pkg::RST_WAIT_TICKS;
      running = 0;
      arc = 0;
      sw = 0;
      tick = '0;
      pend = '0;
      avg = '0;
      cnt = '0;
      skips = wpam_pkg::RST_SKIP_SAMPLES;
      errors = 0;
    endfunction

    function void write_reg(logic [wpam_pkg::REG_BITS-1:0] idx,
                            logic [wpam_pkg::DATA_BITS-1:0] val);
      case (idx)
        wpam_pkg::REG_CURRENT_HIGH:    cur_hi = val[wpam_pkg::SAMPLE_BITS-1:0];
        wpam_pkg::REG_CURRENT_LOW:     cur_lo = val[wpam_pkg::SAMPLE_BITS-1:0];
        wpam_pkg::REG_VOLT_LOW:        v_lo = val[wpam_pkg::SAMPLE_BITS-1:0];
        wpam_pkg::REG_VOLT_HIGH:       v_hi = val[wpam_pkg::SAMPLE_BITS-1:0];
        wpam_pkg::REG_SHORT_THRESHOLD: short_th = val[wpam_pkg::SAMPLE_BITS-1:0];
        wpam_pkg::REG_SKIP_SAMPLES:    skip_n = val[wpam_pkg::SKIP_BITS-1:0];
        wpam_pkg::REG_AVERAGE_SAMPLES: avg_n = val[wpam_pkg::COUNT_BITS-1:0];
        wpam_pkg::REG_WAIT_TICKS:      wait_n = val[wpam_pkg::WAIT_BITS-1:0];
        default: ;
      endcase
    endfunction

    function void stop_pulse();
      running = 0;
      sw = 0;
      tick = '0;
    endfunction

    function void note_input(logic [wpam_pkg::ACTION_BITS-1:0] act,
                             logic [wpam_pkg::PULSE_BITS-1:0] pt,
                             logic [wpam_pkg::SAMPLE_BITS-1:0] v,
                             logic [wpam_pkg::SAMPLE_BITS-1:0] c);
      weld_result_t r;
      longint unsigned sum, n;
      r = '0;
      case (act)
        wpam_pkg::ACT_START: begin
          tick = '0;
          pend = {1'b0, wait_n} + {1'b0, pt};
          running = 1;
        end
        wpam_pkg::ACT_FINISH: stop_pulse();
        wpam_pkg::ACT_TICK: begin
          if (running) begin
            if (tick == 0) sw = 1;
            if (tick == pend) begin
              sw = 0;
              running = 0;
              tick = '1;
            end
            tick = tick + 1'b1;
            if (arc && tick < {1'b0, wait_n}) tick = {1'b0, wait_n};
            if (!arc && tick >= {1'b0, wait_n}) begin
              tick = pend;
              r.fail = 1;
            end
          end
          if (v < short_th) begin
            stop_pulse();
            r.shrt = 1;
            r.short_v = v;
          end
          if (c > cur_hi) begin
            arc = 1;
            if (v > v_lo && v < v_hi) begin
              if (skips == 0 && cnt < avg_n) begin
                n = 64'(cnt) + 64'd1;
                sum = 64'(avg) * 64'(cnt) + (64'(v) << wpam_pkg::FRACTION_BITS);
                avg = wpam_pkg::AVG_BITS'((sum + n / 2) / n);
                cnt = cnt + 1'b1;
              end else if (skips > 0) begin
                skips = skips - 1'b1;
              end
            end
          end else if (arc && c < cur_lo) begin
            arc = 0;
            if (cnt == avg_n && avg > {v_lo, 6'd0} && avg < {v_hi, 6'd0}) begin
              r.rep = 1;
              r.rep_v = avg;
            end
            avg = '0;
            skips = skip_n;
            cnt = '0;
          end
        end
        default: ;
      endcase
      r.sw = sw;
      r.arc = arc;
      expected_q.push_back(r);
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(weld_result_t got);
      weld_result_t want;
      if (expected_q.size() == 0) begin
        $error("result with no item pending");
        errors++;
        return;
      end
      want = expected_q.pop_front();
      check_field("switch_on", 32'(want.sw), 32'(got.sw));
      check_field("arc_present", 32'(want.arc), 32'(got.arc));
      check_field("spark_fail", 32'(want.fail), 32'(got.fail));
      check_field("short_seen", 32'(want.shrt), 32'(got.shrt));
      check_field("short_voltage", 32'(want.short_v), 32'(got.short_v));
      check_field("report_valid", 32'(want.rep), 32'(got.rep));
      check_field("report_voltage", 32'(want.rep_v), 32'(got.rep_v));
    endfunction
  endclass

  logic                             clk;
  logic                             rst = 1'b1;
  logic                             psel = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite = 1'b0;
  logic [wpam_pkg::ADDR_BITS-1:0]   paddr = '0;
  logic [wpam_pkg::DATA_BITS-1:0]   pwdata = '0;
  logic [wpam_pkg::DATA_BITS-1:0]   prdata;
  logic                             pready;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [wpam_pkg::ACTION_BITS-1:0] action = wpam_pkg::ACT_TICK;
  logic [wpam_pkg::PULSE_BITS-1:0]  pulse_ticks = '0;
  logic [wpam_pkg::SAMPLE_BITS-1:0] voltage_sample = '0;
  logic [wpam_pkg::SAMPLE_BITS-1:0] current_sample = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic                             switch_on;
  logic                             arc_present;
  logic                             spark_fail;
  logic                             short_seen;
  logic [wpam_pkg::SAMPLE_BITS-1:0] short_voltage;
  logic                             report_valid;
  logic [wpam_pkg::AVG_BITS-1:0]    report_voltage;

  weld_scoreboard_t sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int sent = 0;

  weld_pulse_and_arc_monitor uut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("weld_pulse_and_arc_monitor regression: fail");
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall)
        sb.check_result(weld_result_t'{switch_on, arc_present, spark_fail, short_seen,
                                       short_voltage, report_valid, report_voltage});
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
      end
    end
  end

  task automatic send_item(logic [wpam_pkg::ACTION_BITS-1:0] act,
                           logic [wpam_pkg::PULSE_BITS-1:0] pt,
                           logic [wpam_pkg::SAMPLE_BITS-1:0] v,
                           logic [wpam_pkg::SAMPLE_BITS-1:0] c);
    if ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < send_idle_pct);
    end
    in_valid <= 1'b1;
    action <= act;
    pulse_ticks <= pt;
    voltage_sample <= v;
    current_sample <= c;
    do @(posedge clk); while (in_stall);
    sb.note_input(act, pt, v, c);
    if (act != ACT_NONE) sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
    repeat (DIVIDE_GAP) @(posedge clk);
  endtask

  task automatic reg_write(logic [wpam_pkg::REG_BITS-1:0] idx,
                           logic [wpam_pkg::DATA_BITS-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  function automatic logic [wpam_pkg::SAMPLE_BITS-1:0] arc_current();
    if (sb.cur_hi == SAMPLE_MAX) return wpam_pkg::SAMPLE_BITS'(SAMPLE_MAX);
    return wpam_pkg::SAMPLE_BITS'($urandom_range(SAMPLE_MAX, sb.cur_hi + 1));
  endfunction

  function automatic logic [wpam_pkg::SAMPLE_BITS-1:0] idle_current();
    if (sb.cur_lo == 0) return '0;
    return wpam_pkg::SAMPLE_BITS'($urandom_range(sb.cur_lo - 1, 0));
  endfunction

  function automatic logic [wpam_pkg::SAMPLE_BITS-1:0] window_volt();
    if (sb.v_hi > sb.v_lo + 1)
      return wpam_pkg::SAMPLE_BITS'($urandom_range(sb.v_hi - 1, sb.v_lo + 1));
    return wpam_pkg::SAMPLE_BITS'($urandom());
  endfunction

  task automatic weld_sequence();
    int pre, arc_n, roll;
    logic [wpam_pkg::PULSE_BITS-1:0] pt;
    pt = ($urandom_range(9, 0) < 8) ? wpam_pkg::PULSE_BITS'($urandom_range(40, 0))
                                    : wpam_pkg::PULSE_BITS'($urandom());
    send_item(wpam_pkg::ACT_START, pt, wpam_pkg::SAMPLE_BITS'($urandom()),
              wpam_pkg::SAMPLE_BITS'($urandom()));
    pre = ($urandom_range(3, 0) == 0) ? $urandom_range(60, 0) : $urandom_range(4, 0);
    repeat (pre)
      send_item(wpam_pkg::ACT_TICK, wpam_pkg::PULSE_BITS'($urandom()), window_volt(),
                wpam_pkg::SAMPLE_BITS'($urandom_range(sb.cur_hi, 0)));
    arc_n = $urandom_range(sb.skip_n + sb.avg_n + 2, 1);
    if (arc_n > 64) arc_n = $urandom_range(64, 1);
    repeat (arc_n) begin
      roll = $urandom_range(99, 0);
      if (roll < 5 && sb.short_th > 0) begin
        send_item(wpam_pkg::ACT_TICK, wpam_pkg::PULSE_BITS'($urandom()),
                  wpam_pkg::SAMPLE_BITS'($urandom_range(sb.short_th - 1, 0)),
                  arc_current());
      end else if (roll < 15) begin
        send_item(wpam_pkg::ACT_TICK, wpam_pkg::PULSE_BITS'($urandom()),
                  wpam_pkg::SAMPLE_BITS'($urandom()), arc_current());
      end else if (roll < 25 && sb.cur_hi >= sb.cur_lo) begin
        send_item(wpam_pkg::ACT_TICK, wpam_pkg::PULSE_BITS'($urandom()), window_volt(),
                  wpam_pkg::SAMPLE_BITS'($urandom_range(sb.cur_hi, sb.cur_lo)));
      end else begin
        send_item(wpam_pkg::ACT_TICK, wpam_pkg::PULSE_BITS'($urandom()), window_volt(),
                  arc_current());
      end
    end
    send_item(wpam_pkg::ACT_TICK, wpam_pkg::PULSE_BITS'($urandom()), window_volt(),
              idle_current());
    if ($urandom_range(2, 0) == 0)
      send_item(wpam_pkg::ACT_FINISH, wpam_pkg::PULSE_BITS'($urandom()),
                wpam_pkg::SAMPLE_BITS'($urandom()), wpam_pkg::SAMPLE_BITS'($urandom()));
  endtask

  task automatic setup_phase(int p);
    logic [wpam_pkg::DATA_BITS-1:0] vals[8];
    int hi, vlo;
    case (p)
      0: begin
        vals[wpam_pkg::REG_CURRENT_HIGH] = wpam_pkg::RST_CURRENT_HIGH;
        vals[wpam_pkg::REG_CURRENT_LOW] = wpam_pkg::RST_CURRENT_LOW;
        vals[wpam_pkg::REG_VOLT_LOW] = wpam_pkg::RST_VOLT_LOW;
        vals[wpam_pkg::REG_VOLT_HIGH] = wpam_pkg::RST_VOLT_HIGH;
        vals[wpam_pkg::REG_SHORT_THRESHOLD] = wpam_pkg::RST_SHORT_THRESHOLD;
        vals[wpam_pkg::REG_SKIP_SAMPLES] = wpam_pkg::RST_SKIP_SAMPLES;
        vals[wpam_pkg::REG_AVERAGE_SAMPLES] = wpam_pkg::RST_AVERAGE_SAMPLES;
        vals[wpam_pkg::REG_WAIT_TICKS] = wpam_pkg::RST_WAIT_TICKS;
      end
      1: begin
        vals[wpam_pkg::REG_CURRENT_HIGH] = 0;
        vals[wpam_pkg::REG_CURRENT_LOW] = SAMPLE_MAX;
        vals[wpam_pkg::REG_VOLT_LOW] = 0;
        vals[wpam_pkg::REG_VOLT_HIGH] = SAMPLE_MAX;
        vals[wpam_pkg::REG_SHORT_THRESHOLD] = 0;
        vals[wpam_pkg::REG_SKIP_SAMPLES] = 0;
        vals[wpam_pkg::REG_AVERAGE_SAMPLES] = 1;
        vals[wpam_pkg::REG_WAIT_TICKS] = 0;
      end
      2: begin
        vals[wpam_pkg::REG_CURRENT_HIGH] = SAMPLE_MAX;
        vals[wpam_pkg::REG_CURRENT_LOW] = 0;
        vals[wpam_pkg::REG_VOLT_LOW] = SAMPLE_MAX;
        vals[wpam_pkg::REG_VOLT_HIGH] = 0;
        vals[wpam_pkg::REG_SHORT_THRESHOLD] = SAMPLE_MAX;
        vals[wpam_pkg::REG_SKIP_SAMPLES] = 255;
        vals[wpam_pkg::REG_AVERAGE_SAMPLES] = 255;
        vals[wpam_pkg::REG_WAIT_TICKS] = 65535;
      end
      3: begin
        // no sample is ever averaged, so no report
        vals[wpam_pkg::REG_CURRENT_HIGH] = 150;
        vals[wpam_pkg::REG_CURRENT_LOW] = 80;
        vals[wpam_pkg::REG_VOLT_LOW] = 50;
        vals[wpam_pkg::REG_VOLT_HIGH] = 950;
        vals[wpam_pkg::REG_SHORT_THRESHOLD] = 10;
        vals[wpam_pkg::REG_SKIP_SAMPLES] = 2;
        vals[wpam_pkg::REG_AVERAGE_SAMPLES] = 0;
        vals[wpam_pkg::REG_WAIT_TICKS] = 5;
      end
      default: begin
        hi = $urandom_range(600, 50);
        vlo = $urandom_range(300, 0);
        vals[wpam_pkg::REG_CURRENT_HIGH] = hi;
        vals[wpam_pkg::REG_CURRENT_LOW] = $urandom_range(hi, 0);
        vals[wpam_pkg::REG_VOLT_LOW] = vlo;
        vals[wpam_pkg::REG_VOLT_HIGH] = $urandom_range(SAMPLE_MAX, vlo + 2);
        vals[wpam_pkg::REG_SHORT_THRESHOLD] = $urandom_range(vlo, 0);
        vals[wpam_pkg::REG_SKIP_SAMPLES] = $urandom_range(8, 0);
        vals[wpam_pkg::REG_AVERAGE_SAMPLES] = $urandom_range(12, 1);
        vals[wpam_pkg::REG_WAIT_TICKS] = $urandom_range(30, 0);
      end
    endcase
    for (int i = 0; i < 8; i++) reg_write(wpam_pkg::REG_BITS'(i), vals[i]);
  endtask

  initial begin
    int target;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 37;
    recv_idle_pct = 61;

    send_item(wpam_pkg::ACT_TICK, '0, '0, '0);
    send_item(wpam_pkg::ACT_TICK, '1, '1, '1);
    send_item(ACT_NONE, '1, '1, '1);
    send_item(wpam_pkg::ACT_START, '1, 10'd500, 10'd0);
    send_item(wpam_pkg::ACT_TICK, 16'd0, 10'd500, 10'd1023);
    send_item(wpam_pkg::ACT_TICK, 16'd0, 10'd19, 10'd1023);
    send_item(wpam_pkg::ACT_START, 16'd0, 10'd0, 10'd0);
    send_item(wpam_pkg::ACT_TICK, 16'd0, 10'd20, 10'd1023);
    send_item(wpam_pkg::ACT_TICK, 16'd0, 10'd500, 10'd1023);
    send_item(wpam_pkg::ACT_TICK, 16'd0, 10'd500, 10'd150);
    send_item(wpam_pkg::ACT_TICK, 16'd0, 10'd500, 10'd99);
    send_item(wpam_pkg::ACT_FINISH, 16'd0, 10'd0, 10'd0);
    send_item(wpam_pkg::ACT_START, 16'd5, 10'd0, 10'd0);
    send_item(wpam_pkg::ACT_TICK, 16'd0, 10'd500, 10'd0);
    // wait time raised while a pulse runs
    drain_results();
    reg_write(wpam_pkg::REG_WAIT_TICKS, 65535);
    repeat (3) send_item(wpam_pkg::ACT_TICK, 16'd0, 10'd500, 10'd1023);
    send_item(wpam_pkg::ACT_TICK, 16'd0, 10'd899, 10'd0);
    send_item(wpam_pkg::ACT_FINISH, 16'd0, 10'd0, 10'd0);
    drain_results();
    reg_write(wpam_pkg::REG_SKIP_SAMPLES, 0);
    reg_write(wpam_pkg::REG_AVERAGE_SAMPLES, 1);
    send_item(wpam_pkg::ACT_TICK, 16'd0, 10'd500, 10'd1023);
    send_item(wpam_pkg::ACT_TICK, 16'd0, 10'd500, 10'd0);
    send_item(wpam_pkg::ACT_TICK, 16'd0, 10'd899, 10'd1023);
    send_item(wpam_pkg::ACT_TICK, 16'd0, 10'd0, 10'd0);

    for (int p = 0; p < 9; p++) begin
      case (p / 3)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 61;
        end
        1: begin
          send_idle_pct = 61;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      drain_results();
      setup_phase(p);
      if (p == 7) hold_left = 400;
      target = sent + ((p == 2) ? 60 : 220);
      while (sent < target) begin
        if ($urandom_range(99, 0) < 80) begin
          weld_sequence();
        end else begin
          send_item(wpam_pkg::ACTION_BITS'($urandom_range(3, 0)),
                    wpam_pkg::PULSE_BITS'($urandom()),
                    wpam_pkg::SAMPLE_BITS'($urandom()),
                    wpam_pkg::SAMPLE_BITS'($urandom()));
        end
      end
    end

    drain_results();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("weld_pulse_and_arc_monitor regression: pass");
    end else begin
      $display("weld_pulse_and_arc_monitor regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/wpam_pkg.sv
hw/rtl/weld_pulse_and_arc_monitor.sv
tb/weld_pulse_and_arc_monitor_tb.sv
